// ----- hw/rtl/pawrl_pkg.sv -----
// Shared constants and types for the per-address window rate limiter.
package pawrl_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int OCC_W         = 11;
    localparam int KEY_W         = 64;
    localparam int CNT_W         = 16;
    localparam int TIME_W        = 32;
    localparam int TALLY_W       = 32;
    localparam int LIM_W         = 16;
    localparam int VERDICT_W     = 2;
    localparam int IN_DATA_W     = 160;
    localparam int OUT_DATA_W    = 64;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [LIM_W-1:0] LIMIT_AT_RESET  = 16'd10;
    localparam logic [LIM_W-1:0] WINDOW_AT_RESET = 16'd60;

    localparam logic [VERDICT_W-1:0] VERDICT_ALLOW  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_REJECT = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FULL   = 2'd2;

    // register select is paddr bit 2 (byte address 4*index)
    localparam logic REG_LIMIT  = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key_upper;
        logic [KEY_W-1:0]  key_lower;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] win_base;
    } t_entry;

endpackage

// ----- hw/rtl/pawrl_table.sv -----
// Address table memory: one write port, one registered read port.
module pawrl_table (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [pawrl_pkg::IDX_W-1:0] i_waddr,
    input  pawrl_pkg::t_entry           i_wdata,
    input  logic [pawrl_pkg::IDX_W-1:0] i_raddr,
    output pawrl_pkg::t_entry           o_rdata
);
    import pawrl_pkg::*;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/per_address_window_rate_limiter.sv -----
// Per-address fixed-window connection rate limiter: one verdict per connection event.
//
// Each transaction on the slave stream is one connection event; exactly one verdict
// transaction follows on the master stream. The block scans its 1024-entry address
// table linearly through the table memory, one entry per clock. On a miss the scan covers
// every entry in use; the verdict is then registered in the done state and the block
// returns to idle, where it can accept the next event. A hit ends the scan early.
// Only one event is in flight at a time, but a finished verdict waits in an output
// register so the next event can be taken before it is consumed; a verdict still
// waiting there holds the next event in its final cycle. The table needs no clearing
// after reset: only entries below the occupancy count are ever read. Registers:
// connection_limit at byte address 0 and window_length at 4, both 16 bits.
module per_address_window_rate_limiter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pawrl_pkg::PADDR_W-1:0]     paddr,
    input  logic [pawrl_pkg::PDATA_W-1:0]     pwdata,
    output logic [pawrl_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    // connection events
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // addr_upper[63:0], addr_lower[127:64], now_seconds[159:128]
    input  logic [pawrl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // verdicts
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // verdict[1:0], address_count[17:2], entries_in_use[28:18],
    // rejections_total[60:29], zero[63:61]
    output logic [pawrl_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import pawrl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         r_state;
    logic [LIM_W-1:0]   r_limit;
    logic [LIM_W-1:0]   r_window;
    logic [OCC_W-1:0]   r_occ;
    logic [TALLY_W-1:0] r_tally;

    logic [KEY_W-1:0]   r_hi;
    logic [KEY_W-1:0]   r_lo;
    logic [TIME_W-1:0]  r_now;
    logic [OCC_W-1:0]   r_scan;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pend_idx;
    logic               r_hit;
    logic [IDX_W-1:0]   r_slot;
    logic [CNT_W-1:0]   r_cnt;
    logic [TIME_W-1:0]  r_ws;

    logic                 r_m_valid;
    logic [VERDICT_W-1:0] r_m_verdict;
    logic [CNT_W-1:0]     r_m_count;
    logic [OCC_W-1:0]     r_m_occ;
    logic [TALLY_W-1:0]   r_m_tally;

    t_entry rdata;
    t_entry wdata;
    logic   we;
    logic [IDX_W-1:0] waddr;

    // ---------------- configuration ----------------
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_AT_RESET;
            r_window <= WINDOW_AT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LIMIT:  r_limit  <= pwdata[LIM_W-1:0];
                REG_WINDOW: r_window <= pwdata[LIM_W-1:0];
                default:    r_limit  <= r_limit;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LIMIT:  prdata = {{(PDATA_W-LIM_W){1'b0}}, r_limit};
            REG_WINDOW: prdata = {{(PDATA_W-LIM_W){1'b0}}, r_window};
            default:    prdata = '0;
        endcase
    end

    // ---------------- table ----------------
    pawrl_table u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_scan[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    // ---------------- event processing ----------------
    logic                 hit_now;
    logic                 more;
    logic                 out_free;
    logic                 expired;
    logic                 full;
    logic [CNT_W-1:0]     base_cnt;
    logic [CNT_W-1:0]     new_cnt;
    logic [TIME_W-1:0]    new_ws;
    logic                 reject;
    logic [TALLY_W-1:0]   new_tally;
    logic [OCC_W-1:0]     new_occ;
    logic [TIME_W-1:0]    elapsed;

    assign hit_now  = r_pend && (rdata.key_upper == r_hi) && (rdata.key_lower == r_lo);
    assign more     = r_scan < r_occ;
    assign out_free = !r_m_valid || m_axis_tready;

    assign elapsed  = r_now - r_ws;
    assign expired  = elapsed >= {{(TIME_W-LIM_W){1'b0}}, r_window};
    assign full     = !r_hit && (r_occ == OCC_W'(TABLE_ENTRIES));
    assign base_cnt = (r_hit && !expired) ? r_cnt : '0;
    assign new_ws   = (r_hit && !expired) ? r_ws : r_now;
    assign new_cnt  = (&base_cnt) ? base_cnt : base_cnt + 1'b1;
    assign reject   = !full && (new_cnt > r_limit);
    assign new_tally = (reject && !(&r_tally)) ? r_tally + 1'b1 : r_tally;
    assign new_occ  = (!r_hit && !full) ? r_occ + 1'b1 : r_occ;

    assign we    = (r_state == ST_DONE) && out_free && !full;
    assign waddr = r_hit ? r_slot : r_occ[IDX_W-1:0];
    assign wdata = '{key_upper: r_hi, key_lower: r_lo, count: new_cnt, win_base: new_ws};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_occ   <= '0;
            r_tally <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
            r_scan  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_scan  <= '0;
                        r_pend  <= 1'b0;
                        r_hit   <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (hit_now) begin
                        r_hit   <= 1'b1;
                        r_pend  <= 1'b0;
                        r_state <= ST_DONE;
                    end else if (more) begin
                        // read of r_scan is issued this cycle, data checked next cycle
                        r_pend <= 1'b1;
                        r_scan <= r_scan + 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_occ   <= new_occ;
                        r_tally <= new_tally;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_hi  <= s_axis_tdata[63:0];
            r_lo  <= s_axis_tdata[127:64];
            r_now <= s_axis_tdata[159:128];
        end
        if (r_state == ST_SCAN) begin
            r_pend_idx <= r_scan[IDX_W-1:0];
        end
        if (hit_now && r_state == ST_SCAN) begin
            r_slot <= r_pend_idx;
            r_cnt  <= rdata.count;
            r_ws   <= rdata.win_base;
        end
        if (r_state == ST_DONE && out_free) begin
            r_m_verdict <= full ? VERDICT_FULL : (reject ? VERDICT_REJECT : VERDICT_ALLOW);
            r_m_count   <= full ? '0 : new_cnt;
            r_m_occ     <= new_occ;
            r_m_tally   <= new_tally;
        end
    end

    // output register: hold the verdict until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_m_tally, r_m_occ, r_m_count, r_m_verdict};

endmodule

// ----- tb/per_address_window_rate_limiter_test.sv -----
// Self-checking testbench for the per-address window rate limiter.
module per_address_window_rate_limiter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pawrl_pkg::*;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [CNT_W-1:0]     count;
        logic [OCC_W-1:0]     entries;
        logic [TALLY_W-1:0]   tally;
    } t_verdict;

    typedef enum logic [1:0] {
        ROW_EVENT,
        ROW_LIMIT,
        ROW_WINDOW
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [KEY_W-1:0]  upper;
        logic [KEY_W-1:0]  lower;
        logic [TIME_W-1:0] now;
        logic [LIM_W-1:0]  value;
        logic              typed;
        t_verdict          want;
    } t_stim_row;

    localparam logic [PADDR_W-1:0] LIMIT_ADDR  = {REG_LIMIT, 2'b00};
    localparam logic [PADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};
    localparam logic [KEY_W-1:0]   ZERO64      = '0;
    localparam logic [KEY_W-1:0]   ONES64      = '1;
    localparam t_verdict           NONE        = '0;
    localparam int                 POOL_KEYS   = 48;
    localparam int                 SEGMENTS    = 7;

    // typed expectations only on the first rows after reset and on the first two zero-limit rows
    localparam t_stim_row DIRECTED_ROWS [23] = '{
        '{ROW_EVENT,  ZERO64, ZERO64, 32'd0,   16'd0, 1'b1, '{VERDICT_ALLOW, 16'd1, 11'd1, 32'd0}},
        '{ROW_EVENT,  ZERO64, ZERO64, 32'd59,  16'd0, 1'b0, NONE},
        '{ROW_EVENT,  ZERO64, ZERO64, 32'd60,  16'd0, 1'b0, NONE},
        '{ROW_EVENT,  ONES64, ONES64, '1,      16'd0, 1'b1, '{VERDICT_ALLOW, 16'd1, 11'd2, 32'd0}},
        '{ROW_EVENT,  ONES64, ZERO64, 32'd100, 16'd0, 1'b0, NONE},
        '{ROW_EVENT,  ZERO64, ONES64, 32'd100, 16'd0, 1'b0, NONE},
        '{ROW_LIMIT,  ZERO64, ZERO64, 32'd0,   16'd0, 1'b0, NONE},
        '{ROW_EVENT,  ZERO64, ZERO64, 32'd61,  16'd0, 1'b1, '{VERDICT_REJECT, 16'd2, 11'd4, 32'd1}},
        '{ROW_EVENT,  64'd1,  64'd2,  32'd7,   16'd0, 1'b1, '{VERDICT_REJECT, 16'd1, 11'd5, 32'd2}},
        '{ROW_WINDOW, ZERO64, ZERO64, 32'd0,   16'd0, 1'b0, NONE},
        '{ROW_EVENT,  64'd1,  64'd2,  32'd7,   16'd0, 1'b0, NONE},
        '{ROW_LIMIT,  ZERO64, ZERO64, 32'd0,   16'd1, 1'b0, NONE},
        '{ROW_EVENT,  64'd1,  64'd2,  32'd7,   16'd0, 1'b0, NONE},
        '{ROW_LIMIT,  ZERO64, ZERO64, 32'd0,   '1,    1'b0, NONE},
        '{ROW_WINDOW, ZERO64, ZERO64, 32'd0,   '1,    1'b0, NONE},
        '{ROW_EVENT,  ZERO64, ZERO64, 32'd65594, 16'd0, 1'b0, NONE},
        '{ROW_EVENT,  ZERO64, ZERO64, 32'd65595, 16'd0, 1'b0, NONE},
        '{ROW_EVENT,  ZERO64, ZERO64, 32'd0,   16'd0, 1'b0, NONE},
        '{ROW_LIMIT,  ZERO64, ZERO64, 32'd0,   16'd2, 1'b0, NONE},
        '{ROW_WINDOW, ZERO64, ZERO64, 32'd0,   16'd100, 1'b0, NONE},
        '{ROW_EVENT,  ONES64, ONES64, 32'd3,   16'd0, 1'b0, NONE},
        '{ROW_EVENT,  ONES64, ONES64, 32'd5,   16'd0, 1'b0, NONE},
        '{ROW_EVENT,  ONES64, ONES64, 32'd10,  16'd0, 1'b0, NONE}
    };

    localparam logic [LIM_W-1:0] SEG_LIMIT  [SEGMENTS] =
        '{16'd10, 16'd3, 16'd0, 16'd65535, 16'd1, 16'd0, 16'd5};
    localparam logic [LIM_W-1:0] SEG_WINDOW [SEGMENTS] =
        '{16'd60, 16'd20, 16'd7, 16'd65535, 16'd0, 16'd0, 16'd300};

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [PADDR_W-1:0]    paddr         = '0;
    logic [PDATA_W-1:0]    pwdata        = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // addr_upper[63:0], addr_lower[127:64], now_seconds[159:128]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // verdict[1:0], address_count[17:2], entries_in_use[28:18],
    // rejections_total[60:29], zero[63:61]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // shadow copy of the address table and counters
    t_entry              shadow_table [TABLE_ENTRIES];
    int unsigned         shadow_used;
    logic [TALLY_W-1:0]  shadow_rejects;
    logic [LIM_W-1:0]    limit_setting;
    logic [LIM_W-1:0]    window_setting;

    t_verdict            pending_verdicts [$];
    int                  mismatches;
    bit                  steady;
    logic [KEY_W-1:0]    pool_upper [POOL_KEYS];
    logic [KEY_W-1:0]    pool_lower [POOL_KEYS];
    logic [TIME_W-1:0]   wall_clock;

    per_address_window_rate_limiter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic t_verdict rate_limit_event(input logic [KEY_W-1:0] upper,
                                                  input logic [KEY_W-1:0] lower,
                                                  input logic [TIME_W-1:0] now);
        t_verdict          r;
        int unsigned       slot;
        bit                hit;
        logic [TIME_W-1:0] elapsed;
        r    = '0;
        slot = 0;
        hit  = 1'b0;
        for (int unsigned i = 0; i < shadow_used && !hit; i++) begin
            if (shadow_table[i].key_upper == upper && shadow_table[i].key_lower == lower) begin
                slot = i;
                hit  = 1'b1;
            end
        end
        if (hit) begin
            // modulo difference: a clock that runs backwards reads as a long gap
            elapsed = now - shadow_table[slot].win_base;
            if (elapsed >= TIME_W'(window_setting)) begin
                shadow_table[slot].count    = '0;
                shadow_table[slot].win_base = now;
            end
        end else if (shadow_used < TABLE_ENTRIES) begin
            slot               = shadow_used;
            shadow_table[slot] = t_entry'{upper, lower, '0, now};
            shadow_used        = shadow_used + 1;
            hit                = 1'b1;
        end
        if (hit) begin
            if (shadow_table[slot].count != '1)
                shadow_table[slot].count = shadow_table[slot].count + 1'b1;
            r.count = shadow_table[slot].count;
            if (r.count > limit_setting) begin
                r.verdict = VERDICT_REJECT;
                if (shadow_rejects != '1)
                    shadow_rejects = shadow_rejects + 1'b1;
            end else begin
                r.verdict = VERDICT_ALLOW;
            end
        end else begin
            r.verdict = VERDICT_FULL;
            r.count   = '0;
        end
        r.entries = OCC_W'(shadow_used);
        r.tally   = shadow_rejects;
        return r;
    endfunction

    task automatic send_event(input logic [KEY_W-1:0] upper, input logic [KEY_W-1:0] lower,
                              input logic [TIME_W-1:0] now, input bit typed,
                              input t_verdict typed_want);
        t_verdict want;
        s_axis_tdata  <= {now, lower, upper};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        want = rate_limit_event(upper, lower, now);
        pending_verdicts.push_back(typed ? typed_want : want);
        if (!steady && $urandom_range(0, 99) < 38) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_verdicts();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic [PADDR_W-1:0] addr, input logic [LIM_W-1:0] want);
        logic [PDATA_W-1:0] back;
        apb_access(1'b0, addr, '0, back);
        if (back !== PDATA_W'(want))
            report_mismatch("register readback", back, want);
    endtask

    task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [LIM_W-1:0] value);
        logic [PDATA_W-1:0] unused;
        apb_access(1'b1, addr, PDATA_W'(value), unused);
        if (addr == LIMIT_ADDR)
            limit_setting = value;
        else
            window_setting = value;
        check_register(addr, value);
    endtask

    task automatic run_segment(input logic [LIM_W-1:0] lim, input logic [LIM_W-1:0] win,
                               input int items);
        logic [KEY_W-1:0] upper;
        logic [KEY_W-1:0] lower;
        int               pick;
        int               idx;
        drain_verdicts();
        write_register(LIMIT_ADDR, lim);
        write_register(WINDOW_ADDR, win);
        repeat (items) begin
            // favor a couple of hot addresses so counts climb past the limit
            idx   = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 1)
                                                 : $urandom_range(0, POOL_KEYS - 1);
            upper = pool_upper[idx];
            lower = pool_lower[idx];
            pick = $urandom_range(0, 99);
            if (pick < 5)
                wall_clock = $urandom;
            else if (pick < 10)
                wall_clock = wall_clock - $urandom_range(1, 50);
            else if (pick < 20)
                wall_clock = wall_clock + win;
            else if (pick < 25)
                wall_clock = wall_clock + win - 1;
            else
                wall_clock = wall_clock + $urandom_range(0, win / 16 + 1);
            send_event(upper, lower, wall_clock, 1'b0, NONE);
        end
    endtask

    // verdict side: random backpressure (none in the steady segment) and field-by-field check
    initial begin
        t_verdict want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("verdict with none pending", m_axis_tdata, 64'd0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_axis_tdata[1:0] !== want.verdict)
                        report_mismatch("verdict", m_axis_tdata[1:0], want.verdict);
                    if (m_axis_tdata[17:2] !== want.count)
                        report_mismatch("address_count", m_axis_tdata[17:2], want.count);
                    if (m_axis_tdata[28:18] !== want.entries)
                        report_mismatch("entries_in_use", m_axis_tdata[28:18], want.entries);
                    if (m_axis_tdata[60:29] !== want.tally)
                        report_mismatch("rejections_total", m_axis_tdata[60:29], want.tally);
                    if (m_axis_tdata[63:61] !== 3'd0)
                        report_mismatch("pad bits", m_axis_tdata[63:61], 64'd0);
                end
            end
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 38);
        end
    end

    initial begin
        logic [LIM_W-1:0] lim;
        logic [LIM_W-1:0] win;
        mismatches     = 0;
        steady         = 1'b0;
        shadow_used    = 0;
        shadow_rejects = '0;
        limit_setting  = LIMIT_AT_RESET;
        window_setting = WINDOW_AT_RESET;
        wall_clock     = 32'd1000;
        for (int i = 0; i < POOL_KEYS; i++) begin
            pool_upper[i] = (i % 4 == 0) ? ZERO64 : {$urandom, $urandom};
            pool_lower[i] = {$urandom, $urandom};
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_register(LIMIT_ADDR, LIMIT_AT_RESET);
        check_register(WINDOW_ADDR, WINDOW_AT_RESET);

        foreach (DIRECTED_ROWS[r]) begin
            case (DIRECTED_ROWS[r].kind)
                ROW_EVENT: begin
                    send_event(DIRECTED_ROWS[r].upper, DIRECTED_ROWS[r].lower,
                               DIRECTED_ROWS[r].now, DIRECTED_ROWS[r].typed,
                               DIRECTED_ROWS[r].want);
                end
                ROW_LIMIT: begin
                    drain_verdicts();
                    write_register(LIMIT_ADDR, DIRECTED_ROWS[r].value);
                end
                default: begin
                    drain_verdicts();
                    write_register(WINDOW_ADDR, DIRECTED_ROWS[r].value);
                end
            endcase
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            lim    = (seg == 5) ? LIM_W'($urandom_range(0, 65535)) : SEG_LIMIT[seg];
            win    = (seg == 5) ? LIM_W'($urandom_range(0, 65535)) : SEG_WINDOW[seg];
            steady = (seg == 2);
            run_segment(lim, win, 80);
        end
        steady = 1'b0;

        drain_verdicts();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
